@@ src/bsws_pkg.sv @@
// ----------------------------------------------------------------------------
// bsws_pkg - shared types and constants for the bounded search stack
// Beat layouts, command and status codes, and the storage geometry.
// ----------------------------------------------------------------------------
package bsws_pkg;

	localparam int DEPTH = 8;
	localparam int DATA_W = 32;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ENTRY_IDX_W = 3;

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_DUMP   = 2'd2,
		CMD_SEARCH = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]               cmd;
		logic signed [DATA_W-1:0] data_value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] entry_value;
		logic [ENTRY_IDX_W-1:0]   entry_index;
		logic                     last_flag;
	} rsp_t;

endpackage

@@ src/bsws_ram.sv @@
// ----------------------------------------------------------------------------
// bsws_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bsws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/bounded_stack_with_search.sv @@
// ----------------------------------------------------------------------------
// bounded_stack_with_search - LIFO stack of signed words with linear search
// Push, pop, dump (bottom to top) and first-match search over a RAM.
// ----------------------------------------------------------------------------
// Push and pop: the result waits in res_q from acceptance and EMIT moves it
// into the output register. Dump: the RAM read register feeds the output
// register, one beat per cycle while the output slot is free, set by the
// single RAM read port. Search: one entry compared per cycle up to a match or
// the top, then EMIT; an empty stack goes straight to EMIT. A new command is
// taken the cycle after the previous command's last beat moves into the output register.
// Reset: fill count cleared (stack empty); RAM contents stay undefined.
module bounded_stack_with_search (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bsws_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bsws_pkg::rsp_t rsp
);
	import bsws_pkg::*;

	// IDLE  : takes a command; push/pop done here, walks start here
	// DUMP  : RAM data for idx_q present; emits one beat per free slot
	// SRCH  : RAM data for idx_q present; compares, one entry a cycle
	// EMIT  : single result waits in res_q for the output register
	typedef enum logic [1:0] {
		S_IDLE,
		S_DUMP,
		S_SRCH,
		S_EMIT
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      fill_q;
	logic [IDX_W-1:0]      idx_q;
	logic [DATA_W-1:0]     key_q;
	rsp_t                  res_q;
	logic                  out_valid_q;
	rsp_t                  out_q;

	logic                  accept;
	logic                  slot_free;
	logic                  out_load;
	logic                  is_full;
	logic                  is_last;
	status_t               start_status;
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [IDX_W-1:0]      ram_raddr;
	logic [DATA_W-1:0]     ram_rdata;

	// Output register can load when empty or drained this cycle
	assign slot_free = !out_valid_q || !rsp_stall;
	// DUMP and EMIT put a beat into a free output slot
	assign out_load  = (state_q == S_DUMP) || (state_q == S_EMIT);
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign is_full   = (fill_q == CNT_W'(DEPTH));
	assign is_last   = ((CNT_W'(idx_q) + CNT_W'(1)) == fill_q);

	// Status of the single result, or of an empty walk, decided at accept
	always_comb begin
		unique case (req.cmd)
			CMD_PUSH:   start_status = is_full ? ST_FULL : ST_OK;
			CMD_POP:    start_status = (fill_q == '0) ? ST_EMPTY : ST_OK;
			CMD_DUMP:   start_status = (fill_q == '0) ? ST_EMPTY : ST_OK;
			CMD_SEARCH: start_status = (fill_q == '0) ? ST_NOTFOUND : ST_OK;
			default:    start_status = ST_OK;
		endcase
	end

	// Push writes straight at the top slot; the next command waits for the
	// EMIT state, so a read never races this write.
	assign ram_we    = accept && (req.cmd == CMD_PUSH) && !is_full;
	assign ram_waddr = IDX_W'(fill_q);

	// Read address: start at the bottom from IDLE, advance when the current
	// entry is consumed, otherwise re-read to hold data under back-pressure.
	always_comb begin
		unique case (state_q)
			S_IDLE: ram_raddr = '0;
			S_DUMP: ram_raddr = slot_free ? idx_q + IDX_W'(1) : idx_q;
			S_SRCH: ram_raddr = idx_q + IDX_W'(1);
			S_EMIT: ram_raddr = idx_q;
			default: ram_raddr = '0;
		endcase
	end

	bsws_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(req.data_value),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			idx_q       <= '0;
			key_q       <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (slot_free) begin
				out_valid_q <= out_load;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						key_q <= req.data_value;
						res_q <= '{status: start_status, entry_value: '0,
							entry_index: '0, last_flag: 1'b1};
						unique case (req.cmd)
							CMD_PUSH: begin
								if (!is_full) begin
									fill_q <= fill_q + CNT_W'(1);
								end
								state_q <= S_EMIT;
							end
							CMD_POP: begin
								if (fill_q != '0) begin
									fill_q <= fill_q - CNT_W'(1);
								end
								state_q <= S_EMIT;
							end
							CMD_DUMP: begin
								if (fill_q == '0) begin
									state_q <= S_EMIT;
								end else begin
									state_q <= S_DUMP;
								end
							end
							CMD_SEARCH: begin
								if (fill_q == '0) begin
									state_q <= S_EMIT;
								end else begin
									state_q <= S_SRCH;
								end
							end
							default: state_q <= S_EMIT;
						endcase
					end
				end
				S_DUMP: begin
					if (slot_free) begin
						out_q.status      <= ST_OK;
						out_q.entry_value <= ram_rdata;
						out_q.entry_index <= ENTRY_IDX_W'(idx_q);
						out_q.last_flag   <= is_last;
						idx_q             <= idx_q + IDX_W'(1);
						if (is_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SRCH: begin
					// first match from the bottom wins
					if (ram_rdata == key_q) begin
						res_q.entry_index <= ENTRY_IDX_W'(idx_q);
						state_q           <= S_EMIT;
					end else if (is_last) begin
						res_q.status <= ST_NOTFOUND;
						state_q      <= S_EMIT;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb - self-checking bench for bounded_stack_with_search
// Drives push, pop, dump and search commands from a directed table and then
// from a biased random stream. A scoreboard predicts every response beat and
// checks each field, with random idling on both channels and one long
// back-pressure hold on the response side.
// ----------------------------------------------------------------------------
module tb;
	import bsws_pkg::*;

	localparam int RST_CYCLES = 7;
	localparam int N_DIR = 24;
	localparam int N_RAND = 500;
	localparam int HOLD_CYCLES = 200;   // long response-side hold-off
	localparam int HOLD_AFTER = 150;    // start it once this many commands went in
	localparam int DRAIN_CYCLES = 24;   // extra drain after the last expected beat
	localparam int WATCHDOG = 2000;     // cycles with no beat on either side

	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct {
		req_t cmd;
		bit   typed;   // expected beat is written in the row
		rsp_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Shadow stack: contents and fill level as the block should hold them.
	logic signed [DATA_W-1:0] stack_mem [DEPTH];
	int stack_fill = 0;
	rsp_t pending_beats [$];

	stim_row_t dir_tab [N_DIR];

	int n_req = 0;
	int n_rsp = 0;
	int n_full = 0;
	int n_empty = 0;
	int n_found = 0;
	int n_missed = 0;
	int n_dumped = 0;
	int errors = 0;
	int idle_cycles = 0;

	bounded_stack_with_search DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one accepted command to the shadow stack and queue the beats it
	// should produce. With keep clear only the state moves (the row supplies
	// its own expected beat).
	task automatic apply_stack_cmd(input req_t b, input bit keep);
		rsp_t beat;
		bit single;
		bit hit;
		int i;
		beat = '0;
		beat.last_flag = 1'b1;
		single = 1'b1;
		hit = 1'b0;
		case (cmd_t'(b.cmd))
			CMD_PUSH: begin
				if (stack_fill < DEPTH) begin
					stack_mem[stack_fill] = b.data_value;
					stack_fill++;
					beat.status = ST_OK;
				end else begin
					beat.status = ST_FULL;
					n_full++;
				end
			end
			CMD_POP: begin
				if (stack_fill > 0) begin
					stack_fill--;
					beat.status = ST_OK;
				end else begin
					beat.status = ST_EMPTY;
					n_empty++;
				end
			end
			CMD_DUMP: begin
				if (stack_fill == 0) begin
					beat.status = ST_EMPTY;
					n_empty++;
				end else begin
					// bottom to top, last flag on the top entry only
					single = 1'b0;
					for (i = 0; i < stack_fill; i++) begin
						beat.status = ST_OK;
						beat.entry_value = stack_mem[i];
						beat.entry_index = i[ENTRY_IDX_W-1:0];
						beat.last_flag = (i == stack_fill - 1);
						n_dumped++;
						if (keep)
							pending_beats.push_back(beat);
					end
				end
			end
			default: begin
				// first match from the bottom wins
				for (i = 0; i < stack_fill; i++) begin
					if (!hit && stack_mem[i] == b.data_value) begin
						hit = 1'b1;
						beat.entry_index = i[ENTRY_IDX_W-1:0];
					end
				end
				beat.status = hit ? ST_OK : ST_NOTFOUND;
				if (hit)
					n_found++;
				else
					n_missed++;
			end
		endcase
		if (single && keep)
			pending_beats.push_back(beat);
	endtask

	function automatic rsp_t quick_beat(input status_t st, input int idx);
		rsp_t beat;
		beat = '0;
		beat.status = st;
		beat.entry_index = idx[ENTRY_IDX_W-1:0];
		beat.last_flag = 1'b1;
		return beat;
	endfunction

	function automatic stim_row_t stim_row(input cmd_t c, input logic signed [DATA_W-1:0] v,
			input bit typed, input status_t st, input int idx);
		stim_row_t row;
		row.cmd.cmd = c;
		row.cmd.data_value = v;
		row.typed = typed;
		row.want = quick_beat(st, idx);
		return row;
	endfunction

	// Idle length: mostly none, some short, a few long. Calm means no idling.
	function automatic int idle_len(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Small values give duplicates for search, extremes hit the sign edges,
	// full-range values toggle every bit.
	function automatic logic signed [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return int'($urandom_range(0, 7)) - 4;
		if (r < 6) begin
			case ($urandom_range(0, 3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return '0;
				default: return '1;
			endcase
		end
		return $urandom;
	endfunction

	// Push-heavy or pop-heavy depending on the current tilt, so the stack
	// keeps swinging between empty and full.
	function automatic req_t pick_cmd(input bit fill_bias);
		req_t b;
		int r;
		r = $urandom_range(0, 99);
		b.data_value = pick_value();
		if (r < (fill_bias ? 50 : 15))
			b.cmd = CMD_PUSH;
		else if (r < 65)
			b.cmd = CMD_POP;
		else if (r < 75)
			b.cmd = CMD_DUMP;
		else begin
			b.cmd = CMD_SEARCH;
			// mostly look for something that is on the stack
			if (stack_fill > 0 && $urandom_range(0, 9) < 6)
				b.data_value = stack_mem[$urandom_range(0, stack_fill - 1)];
		end
		if (b.cmd == CMD_POP && !fill_bias && r >= 50)
			b.cmd = CMD_PUSH;
		return b;
	endfunction

	// Offer one command, hold it until taken, then model it and idle.
	task automatic offer_cmd(input req_t b, input bit typed, input rsp_t want,
			input int gap);
		req <= b;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		n_req++;
		apply_stack_cmd(b, !typed);
		if (typed)
			pending_beats.push_back(want);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Request side: reset, directed table, random stream, drain, verdict.
	initial begin : req_side
		req_t b;
		int k;
		int tilt_left;
		bit fill_bias;
		bit calm;
		// Directed table. Single-beat results that follow straight from the
		// command are written in; dumps and the deeper searches go through
		// the shadow stack.
		dir_tab[0]  = stim_row(CMD_POP,    '0,      1, ST_EMPTY,    0);
		dir_tab[1]  = stim_row(CMD_DUMP,   '0,      1, ST_EMPTY,    0);
		dir_tab[2]  = stim_row(CMD_SEARCH, '0,      1, ST_NOTFOUND, 0);
		dir_tab[3]  = stim_row(CMD_PUSH,   VAL_MIN, 1, ST_OK,       0);
		dir_tab[4]  = stim_row(CMD_SEARCH, VAL_MIN, 1, ST_OK,       0);
		dir_tab[5]  = stim_row(CMD_POP,    '1,      1, ST_OK,       0);
		// popped word is still in the RAM but must not be found
		dir_tab[6]  = stim_row(CMD_SEARCH, VAL_MIN, 1, ST_NOTFOUND, 0);
		dir_tab[7]  = stim_row(CMD_PUSH,   VAL_MIN, 1, ST_OK,       0);
		dir_tab[8]  = stim_row(CMD_PUSH,   VAL_MAX, 1, ST_OK,       0);
		dir_tab[9]  = stim_row(CMD_PUSH,   '0,      1, ST_OK,       0);
		dir_tab[10] = stim_row(CMD_PUSH,   '1,      1, ST_OK,       0);
		dir_tab[11] = stim_row(CMD_PUSH,   32'sh5555_5555, 1, ST_OK, 0);
		dir_tab[12] = stim_row(CMD_PUSH,   32'shaaaa_aaaa, 1, ST_OK, 0);
		dir_tab[13] = stim_row(CMD_PUSH,   32'sd1,  1, ST_OK,       0);
		dir_tab[14] = stim_row(CMD_PUSH,   '0,      1, ST_OK,       0);
		dir_tab[15] = stim_row(CMD_PUSH,   32'sd7,  1, ST_FULL,     0);
		dir_tab[16] = stim_row(CMD_DUMP,   '0,      0, ST_OK,       0);
		// zero sits at 2 and again on top: first match wins
		dir_tab[17] = stim_row(CMD_SEARCH, '0,      1, ST_OK,       2);
		dir_tab[18] = stim_row(CMD_SEARCH, '1,      0, ST_OK,       0);
		dir_tab[19] = stim_row(CMD_SEARCH, 32'sd1,  0, ST_OK,       0);
		dir_tab[20] = stim_row(CMD_SEARCH, VAL_MAX, 0, ST_OK,       0);
		dir_tab[21] = stim_row(CMD_POP,    '0,      1, ST_OK,       0);
		dir_tab[22] = stim_row(CMD_DUMP,   '1,      0, ST_OK,       0);
		dir_tab[23] = stim_row(CMD_SEARCH, 32'sd5,  1, ST_NOTFOUND, 0);

		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < N_DIR; k++)
			offer_cmd(dir_tab[k].cmd, dir_tab[k].typed, dir_tab[k].want, idle_len(1'b0));

		fill_bias = 1'b0;
		tilt_left = 0;
		calm = 1'b0;
		for (k = 0; k < N_RAND; k++) begin
			if (tilt_left == 0) begin
				fill_bias = ~fill_bias;
				tilt_left = $urandom_range(10, 40);
				calm = ($urandom_range(0, 3) == 0);
			end
			tilt_left--;
			b = pick_cmd(fill_bias);
			offer_cmd(b, 1'b0, '0, idle_len(calm));
		end
		req_valid <= 1'b0;

		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d commands, %0d response beats (%0d dump beats).",
			n_req, n_rsp, n_dumped);
		$display("Full %0d, empty %0d, found %0d, not found %0d, %0d errors.",
			n_full, n_empty, n_found, n_missed, errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Response side: random stall, calm stretches, and one long hold-off
	// while commands keep coming so the block backs up into req_stall.
	initial begin : rsp_side
		int len;
		int calm_left;
		bit held;
		calm_left = 0;
		held = 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!held && n_req >= HOLD_AFTER) begin
				held = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (calm_left > 0) begin
				calm_left--;
				rsp_stall <= 1'b0;
				@(posedge clk);
			end else begin
				if ($urandom_range(0, 99) < 4)
					calm_left = $urandom_range(20, 80);
				len = idle_len(1'b0);
				if (len == 0) begin
					rsp_stall <= 1'b0;
					@(posedge clk);
				end else begin
					rsp_stall <= 1'b1;
					repeat (len) @(posedge clk);
					rsp_stall <= 1'b0;
					@(posedge clk);
				end
			end
		end
	end

	// Scoreboard: every taken response beat against the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			n_rsp++;
			if (pending_beats.size() == 0) begin
				$error("unexpected beat: status %0d value %0d index %0d last %0b",
					rsp.status, rsp.entry_value, rsp.entry_index, rsp.last_flag);
				errors++;
			end else begin
				want = pending_beats.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					errors++;
				end
				if (rsp.entry_value !== want.entry_value) begin
					$error("entry_value: expected %0d, got %0d",
						want.entry_value, rsp.entry_value);
					errors++;
				end
				if (rsp.entry_index !== want.entry_index) begin
					$error("entry_index: expected %0d, got %0d",
						want.entry_index, rsp.entry_index);
					errors++;
				end
				if (rsp.last_flag !== want.last_flag) begin
					$error("last_flag: expected %0b, got %0b",
						want.last_flag, rsp.last_flag);
					errors++;
				end
			end
		end
	end

	// Watchdog: too long without a beat on either channel means a hang.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else if (idle_cycles + 1 >= WATCHDOG) begin
			$display("hang: no beat for %0d cycles, %0d beats still expected",
				WATCHDOG, pending_beats.size());
			$display("*** FAILED ***");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule

@@ filelist.f @@
src/bsws_pkg.sv
src/bsws_ram.sv
src/bounded_stack_with_search.sv
tb/sv/tb.sv
